@@ rtl/core/sbid_pkg.sv @@
// ----------------------------------------------------------------------------
// sbid_pkg
// Types and constants shared by the sixteen-bit instruction decoder: the
// instruction kinds, operand modes and the field widths of the decoded beat.
// ----------------------------------------------------------------------------
package sbid_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned ADDR_W = 22;
  localparam int unsigned IMM_W  = 6;
  localparam int unsigned REG_W  = 3;

  // Special encodings.
  localparam logic [WORD_W-1:0] WORD_ZERO = 16'h0000;
  localparam logic [WORD_W-1:0] WORD_ONES = 16'hffff;
  localparam logic [WORD_W-1:0] RETF_WORD = 16'h9a90;
  localparam logic [WORD_W-1:0] RETI_WORD = 16'h9a98;
  localparam logic [IMM_W-1:0]  INTCTL_SPECIAL = 6'h25;

  // Register numbers with a special role.
  localparam logic [REG_W-1:0] REG_SP = 3'd0;
  localparam logic [REG_W-1:0] REG_PC = 3'd7;

  // Opcode groups of the top four bits.
  localparam logic [3:0] OP0_CMP  = 4'd4;
  localparam logic [3:0] OP0_BAD5 = 4'd5;
  localparam logic [3:0] OP0_TEST = 4'd6;
  localparam logic [3:0] OP0_BAD7 = 4'd7;
  localparam logic [3:0] OP0_LD   = 4'd9;
  localparam logic [3:0] OP0_TST2 = 4'd12;
  localparam logic [3:0] OP0_ST   = 4'd13;
  localparam logic [3:0] OP0_JMP  = 4'd14;
  localparam logic [3:0] OP0_EXT  = 4'd15;

  typedef enum logic [3:0] {
    K_INVALID = 4'd0,
    K_BAD     = 4'd1,
    K_UNKNOWN = 4'd2,
    K_BRANCH  = 4'd3,
    K_ALU     = 4'd4,
    K_STORE   = 4'd5,
    K_POP     = 4'd6,
    K_PUSH    = 4'd7,
    K_RETF    = 4'd8,
    K_RETI    = 4'd9,
    K_CALL    = 4'd10,
    K_GOTO    = 4'd11,
    K_MUL     = 4'd12,
    K_INTCTL  = 4'd13
  } kind_t;

  typedef enum logic [3:0] {
    M_BP_DISP  = 4'd0,
    M_IMM6     = 4'd1,
    M_INDIRECT = 4'd2,
    M_REG      = 4'd3,
    M_IMM16    = 4'd4,
    M_DIRECT16 = 4'd5,
    M_ST_DIR16 = 4'd6,
    M_ASR      = 4'd7,
    M_LSL      = 4'd8,
    M_LSR      = 4'd9,
    M_ROL      = 4'd10,
    M_ROR      = 4'd11,
    M_DIRECT6  = 4'd12
  } mode_t;

  // Source of the value field, resolved in the last stage.
  typedef enum logic [2:0] {
    V_ZERO,
    V_IMM,
    V_EXT,
    V_FAR,
    V_TARGET
  } vsel_t;

endpackage

@@ rtl/core/sixteen_bit_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// sixteen_bit_instruction_decoder
// Three-stage pipelined decoder for one 16-bit instruction word per beat.
// ----------------------------------------------------------------------------
// The decoder accepts one instruction beat per clock while in_ready is high
// and returns its decoded description in order, one result beat per input beat.
// Stage one registers the words with the incremented address and the length,
// stage two classifies the encoding and forms the branch target with one
// 22-bit add or subtract, stage three selects the value field into the output
// register. Each stage holds a valid bit and moves on only when the stage
// after it is empty or moving, so the sustained rate is one beat per cycle
// whenever out_ready is high; a stall on the result side fills the three
// stages before in_ready drops.
module sixteen_bit_instruction_decoder
  import sbid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_instr_word,
  input  logic [WORD_W-1:0] in_ext_word,
  input  logic [ADDR_W-1:0] in_instr_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_word_count,
  output logic [3:0]        out_kind,
  output logic [3:0]        out_alu_op,
  output logic [REG_W-1:0]  out_dest_reg,
  output logic [REG_W-1:0]  out_src_reg,
  output logic [3:0]        out_operand_mode,
  output logic [IMM_W-1:0]  out_mode_detail,
  output logic [REG_W-1:0]  out_first_reg,
  output logic [REG_W-1:0]  out_last_reg,
  output logic [ADDR_W-1:0] out_value
);

  typedef struct packed {
    logic [WORD_W-1:0] op;
    logic [WORD_W-1:0] ext;
    logic [ADDR_W-1:0] next_addr;
    logic [1:0]        words;
    logic              invalid;
  } s1_t;

  typedef struct packed {
    logic [WORD_W-1:0] op;
    logic [WORD_W-1:0] ext;
    logic [ADDR_W-1:0] target;
    logic [1:0]        words;
    kind_t             kind;
    mode_t             mode;
    logic [IMM_W-1:0]  detail;
    logic [REG_W-1:0]  first;
    logic [REG_W-1:0]  last;
    vsel_t             vsel;
  } s2_t;

  typedef struct packed {
    logic [1:0]        words;
    kind_t             kind;
    logic [3:0]        alu_op;
    logic [REG_W-1:0]  dest;
    logic [REG_W-1:0]  src;
    mode_t             mode;
    logic [IMM_W-1:0]  detail;
    logic [REG_W-1:0]  first;
    logic [REG_W-1:0]  last;
    logic [ADDR_W-1:0] value;
  } s3_t;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;

  // Field split of the word held in stage one.
  logic [3:0]       op0;
  logic [REG_W-1:0] ra, op1, n, rb;
  logic [IMM_W-1:0] imm;
  logic             restricted;
  logic [3:0]       ra_w, n_w;

  // Stage one: length, invalid words and the following address.
  logic [3:0] in_op0;
  logic [2:0] in_op1, in_n;
  logic       in_long;

  // A stage advances when the stage after it is empty or moving.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    in_op0  = in_instr_word[15:12];
    in_op1  = in_instr_word[8:6];
    in_n    = in_instr_word[5:3];
    in_long = ((in_op0 < OP0_JMP) && (in_op1 == 3'd4) && (in_n >= 3'd1) && (in_n <= 3'd3))
              || ((in_op0 == OP0_EXT) && ((in_op1 == 3'd1) || (in_op1 == 3'd2)));
    s1_nxt.op        = in_instr_word;
    s1_nxt.ext       = in_ext_word;
    s1_nxt.next_addr = in_instr_address + ADDR_W'(1);
    s1_nxt.invalid   = (in_instr_word == WORD_ZERO) || (in_instr_word == WORD_ONES);
    s1_nxt.words     = (in_long && !s1_nxt.invalid) ? 2'd2 : 2'd1;
  end

  // Stage two: classify the encoding and form the branch target.
  always_comb begin
    op0        = s1_r.op[15:12];
    ra         = s1_r.op[11:9];
    op1        = s1_r.op[8:6];
    n          = s1_r.op[5:3];
    rb         = s1_r.op[2:0];
    imm        = s1_r.op[5:0];
    ra_w       = {1'b0, ra};
    n_w        = {1'b0, n};
    restricted = ((op0 == OP0_CMP) || (op0 == OP0_TST2) || (op0 == OP0_TEST)
                  || (op0 == OP0_LD)) && (ra != rb);

    s2_nxt.op     = s1_r.op;
    s2_nxt.ext    = s1_r.ext;
    s2_nxt.words  = s1_r.words;
    s2_nxt.kind   = K_UNKNOWN;
    s2_nxt.mode   = M_BP_DISP;
    s2_nxt.detail = '0;
    s2_nxt.first  = '0;
    s2_nxt.last   = '0;
    s2_nxt.vsel   = V_ZERO;
    s2_nxt.target = (op1 == 3'd0) ? (s1_r.next_addr + ADDR_W'(imm))
                                  : (s1_r.next_addr - ADDR_W'(imm));

    if (s1_r.invalid) begin
      s2_nxt.kind = K_INVALID;
    end else if ((op0 != OP0_EXT) && (ra == REG_PC) && (op1 <= 3'd1)) begin
      s2_nxt.kind = K_BRANCH;
      s2_nxt.vsel = V_TARGET;
    end else if ((op0 == OP0_BAD5) || (op0 == OP0_BAD7)) begin
      s2_nxt.kind = K_BAD;
    end else if (op0 == OP0_JMP) begin
      s2_nxt.kind = K_UNKNOWN;
    end else if (op0 == OP0_EXT) begin
      // Extended group: multiply, far call, far jump, interrupt control.
      case (op1)
        3'd0, 3'd4: begin
          if ((n == 3'd1) && (ra != REG_PC)) begin
            s2_nxt.kind   = K_MUL;
            s2_nxt.mode   = M_REG;
            s2_nxt.detail = (op1 == 3'd0) ? IMM_W'(1) : IMM_W'(0);
          end
        end
        3'd1: begin
          if (ra == REG_SP) begin
            s2_nxt.kind = K_CALL;
            s2_nxt.vsel = V_FAR;
          end
        end
        3'd2: begin
          if (ra == REG_PC) begin
            s2_nxt.kind = K_GOTO;
            s2_nxt.vsel = V_FAR;
          end
        end
        3'd5: begin
          if ((ra == REG_SP) && ((imm <= 6'd5) || (imm == 6'd8) || (imm == 6'd9)
              || (imm == 6'd12) || (imm == 6'd14) || (imm == INTCTL_SPECIAL))) begin
            s2_nxt.kind   = K_INTCTL;
            s2_nxt.detail = imm;
          end
        end
        default: begin
          s2_nxt.kind = K_UNKNOWN;
        end
      endcase
    end else if (op0 == OP0_ST) begin
      // Store group, with push.
      s2_nxt.kind = K_BAD;
      case (op1)
        3'd0: begin
          s2_nxt.kind = K_STORE;
          s2_nxt.vsel = V_IMM;
        end
        3'd2: begin
          if (((ra_w + 4'd1) >= n_w) && (ra_w < (n_w + 4'd7))) begin
            s2_nxt.kind  = K_PUSH;
            s2_nxt.first = ra + 3'd1 - n;
            s2_nxt.last  = ra;
          end
        end
        3'd3: begin
          s2_nxt.kind   = K_STORE;
          s2_nxt.mode   = M_INDIRECT;
          s2_nxt.detail = IMM_W'(n);
        end
        3'd4: begin
          if ((n == 3'd3) && (ra == rb)) begin
            s2_nxt.kind = K_STORE;
            s2_nxt.mode = M_ST_DIR16;
            s2_nxt.vsel = V_EXT;
          end
        end
        3'd7: begin
          s2_nxt.kind = K_STORE;
          s2_nxt.mode = M_DIRECT6;
          s2_nxt.vsel = V_IMM;
        end
        default: begin
          s2_nxt.kind = K_BAD;
        end
      endcase
    end else begin
      // ALU group.
      s2_nxt.kind = K_ALU;
      case (op1)
        3'd0: begin
          s2_nxt.mode = M_BP_DISP;
          s2_nxt.vsel = V_IMM;
        end
        3'd1: begin
          s2_nxt.mode = M_IMM6;
          s2_nxt.vsel = V_IMM;
        end
        3'd2: begin
          s2_nxt.kind = K_BAD;
          if (op0 == OP0_LD) begin
            if (s1_r.op == RETF_WORD) begin
              s2_nxt.kind = K_RETF;
            end else if (s1_r.op == RETI_WORD) begin
              s2_nxt.kind = K_RETI;
            end else if ((ra != REG_PC) && ((ra_w + n_w) < 4'd8)) begin
              s2_nxt.kind  = K_POP;
              s2_nxt.first = ra + 3'd1;
              s2_nxt.last  = ra + n;
            end
          end
        end
        3'd3: begin
          s2_nxt.mode   = M_INDIRECT;
          s2_nxt.detail = IMM_W'(n);
        end
        3'd4: begin
          case (n)
            3'd0: begin
              s2_nxt.mode = M_REG;
            end
            3'd1: begin
              if (restricted) begin
                s2_nxt.kind = K_BAD;
              end else begin
                s2_nxt.mode = M_IMM16;
                s2_nxt.vsel = V_EXT;
              end
            end
            3'd2: begin
              if (restricted) begin
                s2_nxt.kind = K_BAD;
              end else begin
                s2_nxt.mode = M_DIRECT16;
                s2_nxt.vsel = V_EXT;
              end
            end
            3'd3: begin
              if ((op0 == OP0_CMP) || (op0 == OP0_TST2) || restricted) begin
                s2_nxt.kind = K_BAD;
              end else begin
                s2_nxt.mode = M_ST_DIR16;
                s2_nxt.vsel = V_EXT;
              end
            end
            default: begin
              s2_nxt.mode   = M_ASR;
              s2_nxt.detail = IMM_W'(n[1:0]);
            end
          endcase
        end
        3'd5: begin
          s2_nxt.mode   = n[2] ? M_LSR : M_LSL;
          s2_nxt.detail = IMM_W'(n[1:0]);
        end
        3'd6: begin
          s2_nxt.mode   = n[2] ? M_ROR : M_ROL;
          s2_nxt.detail = IMM_W'(n[1:0]);
        end
        default: begin
          s2_nxt.mode = M_DIRECT6;
          s2_nxt.vsel = V_IMM;
        end
      endcase
    end
  end

  // Stage three: select the value field.
  always_comb begin
    s3_nxt.words  = s2_r.words;
    s3_nxt.kind   = s2_r.kind;
    s3_nxt.alu_op = s2_r.op[15:12];
    s3_nxt.dest   = s2_r.op[11:9];
    s3_nxt.src    = s2_r.op[2:0];
    s3_nxt.mode   = s2_r.mode;
    s3_nxt.detail = s2_r.detail;
    s3_nxt.first  = s2_r.first;
    s3_nxt.last   = s2_r.last;
    case (s2_r.vsel)
      V_IMM:    s3_nxt.value = ADDR_W'(s2_r.op[5:0]);
      V_EXT:    s3_nxt.value = ADDR_W'(s2_r.ext);
      V_FAR:    s3_nxt.value = {s2_r.op[5:0], s2_r.ext};
      V_TARGET: s3_nxt.value = s2_r.target;
      default:  s3_nxt.value = '0;
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid        = v3_r;
  assign out_word_count   = s3_r.words;
  assign out_kind         = s3_r.kind;
  assign out_alu_op       = s3_r.alu_op;
  assign out_dest_reg     = s3_r.dest;
  assign out_src_reg      = s3_r.src;
  assign out_operand_mode = s3_r.mode;
  assign out_mode_detail  = s3_r.detail;
  assign out_first_reg    = s3_r.first;
  assign out_last_reg     = s3_r.last;
  assign out_value        = s3_r.value;

  // An invalid word is always reported as one word long.
  a_invalid_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == K_INVALID)) |-> (out_word_count == 2'd1))
    else $error("invalid word reported with a length other than one");

  // A branch is only ever decoded with the program counter as destination.
  a_branch_pc : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == K_BRANCH)) |-> (out_dest_reg == REG_PC))
    else $error("branch decoded without the program counter field");

  // With all three stages full and the output stalled, no beat is taken.
  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_ready) |-> !in_ready)
    else $error("input beat taken while the pipeline is full and stalled");

endmodule
